// ----- design/swm_pkg.sv -----
package swm_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int CFG_W          = 7;
  localparam int MAX_WINDOW_DEF = 64;

  localparam logic [CFG_W-1:0]    WINDOW_RESET = 7'd5;
  // flipping the sign bit makes unsigned compare follow signed order
  localparam logic [SAMPLE_W-1:0] SIGN_FLIP    = 32'h8000_0000;

  // what a cell shows its neighbors each cycle
  typedef struct packed {
    logic [SAMPLE_W-1:0] val;  // stored sample, sign-flipped
    logic                le;   // val <= incoming sample
    logic                sh;   // at or right of the slot being evicted
  } swm_link_t;

endpackage

// ----- design/swm_cell.sv -----
module swm_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7,
  parameter int AW  = 6
) (
  input  logic                                clk,
  input  logic                                upd,
  input  logic [swm_pkg::SAMPLE_W-1:0]        x,
  input  logic [swm_pkg::SAMPLE_W-1:0]        r,
  input  logic                                full,
  input  logic [CW-1:0]                       len_p,
  input  swm_pkg::swm_link_t                  lnk_lt,
  input  logic [AW-1:0]                       age_lt,
  input  swm_pkg::swm_link_t                  lnk_rt,
  input  logic [AW-1:0]                       age_rt,
  output swm_pkg::swm_link_t                  lnk_o,
  output logic [AW-1:0]                       age_o
);

  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] PREV_C = CW'((IDX > 0) ? (IDX - 1) : 0);
  localparam logic          HAS_L  = (IDX > 0);

  logic [swm_pkg::SAMPLE_W-1:0] val_r, val_nxt;
  logic [AW-1:0]                age_r, age_nxt;
  logic                         le_own, sh_own;
  logic                         lo, hi;
  logic [swm_pkg::SAMPLE_W-1:0] cur_v, prv_v;
  logic [AW-1:0]                cur_a, prv_a;

  assign le_own = (val_r <= x);
  assign sh_own = full && (val_r >= r);

  assign lnk_o.val = val_r;
  assign lnk_o.le  = le_own;
  assign lnk_o.sh  = sh_own;
  assign age_o     = age_r;

  // window with the evicted entry closed up: slot IDX and slot IDX-1
  assign cur_v = sh_own ? lnk_rt.val : val_r;
  assign cur_a = sh_own ? age_rt     : age_r;
  assign prv_v = lnk_lt.sh ? val_r : lnk_lt.val;
  assign prv_a = lnk_lt.sh ? age_r : age_lt;

  assign lo = (IDX_C < len_p) && (sh_own ? lnk_rt.le : le_own);
  assign hi = HAS_L && (PREV_C < len_p) && !(lnk_lt.sh ? le_own : lnk_lt.le);

  always_comb begin
    val_nxt = val_r;
    age_nxt = age_r;
    if (lo) begin
      val_nxt = cur_v;
      age_nxt = cur_a + AW'(1);
    end else if (hi) begin
      val_nxt = prv_v;
      age_nxt = prv_a + AW'(1);
    end else begin
      val_nxt = x;
      age_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

endmodule

// ----- design/sliding_window_median.sv -----
// Running median filter over signed 32-bit samples. Each accepted word enters
// a window of the last N samples, N being the window length register
// (1..MAX_WINDOW; 0 acts as 1, larger values clamp to MAX_WINDOW). Once a
// sequence has brought N samples, every further word yields one result: the
// sorted element at index N/2, i.e. the upper median for even sizes. While the
// window fills no result is produced. in_new_sequence restarts the fill; a
// config write does too. The window lives in a row of MAX_WINDOW sort cells,
// kept in ascending order with an age tag each; one word is absorbed per clock
// (eviction of the oldest and sorted insertion happen together, each cell
// looking only at its two neighbors). A result moves from the pending
// register to the output register, raising out_valid; sustained rate is one
// word per cycle unless the output is stalled. No init sweep after reset.
module sliding_window_median #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 in_new_sequence,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [swm_pkg::SAMPLE_W-1:0]  out_median,
  // window length register
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [swm_pkg::CFG_W-1:0]            cfg_win_len
);

  localparam int CW = $clog2(MAX_WINDOW + 1);  // fill count / window size
  localparam int AW = $clog2(MAX_WINDOW);      // cell index and age

  // ---------------- config ----------------
  logic [swm_pkg::CFG_W-1:0] ws_r, ws_nxt;
  logic [CW-1:0]             weff;
  logic                      cfg_wr;

  always_comb begin
    if (ws_r == '0)
      weff = CW'(1);
    else if (32'(ws_r) > 32'(MAX_WINDOW))
      weff = CW'(MAX_WINDOW);
    else
      weff = CW'(ws_r);
  end

  // ---------------- handshake ----------------
  logic pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [swm_pkg::SAMPLE_W-1:0] out_median_r, out_median_nxt;
  logic out_load, accept;

  assign cfg_ready = !pend_r;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // pending result moves to the output reg when that reg is free or draining
  assign out_load = pend_r && (!out_valid_r || !out_stall);
  assign in_stall = pend_r && !out_load;
  assign accept   = in_valid && !in_stall;

  // ---------------- fill / eviction control ----------------
  logic [CW-1:0]                cnt_r, cnt_nxt, cnt0, len_p, cnt_new;
  logic                         full, produce;
  logic [swm_pkg::SAMPLE_W-1:0] x, r;

  assign x = in_sample ^ swm_pkg::SIGN_FLIP;

  always_comb begin
    cnt0 = cnt_r;
    if (in_new_sequence || (cnt_r > weff)) cnt0 = '0;
    full    = (cnt0 == weff);
    len_p   = full ? (weff - CW'(1)) : cnt0;   // entries left after eviction
    cnt_new = full ? weff : (cnt0 + CW'(1));
    produce = (cnt_new == weff);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cfg_wr)      cnt_nxt = '0;
    else if (accept) cnt_nxt = cnt_new;
  end

  // ---------------- cell row ----------------
  swm_pkg::swm_link_t lnk [MAX_WINDOW];
  logic [AW-1:0]      age [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] kill;

  // oldest entry: the valid cell whose age is window-1 (at most one)
  always_comb begin
    r = '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      kill[k] = (CW'(k) < cnt_r) && ({1'b0, age[k]} == CW'(weff - CW'(1)));
      if (kill[k]) r = r | lnk[k].val;
    end
  end

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    swm_pkg::swm_link_t ll, lr;
    logic [AW-1:0]      al, ar;
    if (j == 0) begin : g_l0
      assign ll = '0;
      assign al = '0;
    end else begin : g_ln
      assign ll = lnk[j-1];
      assign al = age[j-1];
    end
    if (j == MAX_WINDOW - 1) begin : g_r0
      assign lr = '0;
      assign ar = '0;
    end else begin : g_rn
      assign lr = lnk[j+1];
      assign ar = age[j+1];
    end
    swm_cell #(.IDX(j), .CW(CW), .AW(AW)) u_cell (
      .clk    (clk),
      .upd    (accept),
      .x      (x),
      .r      (r),
      .full   (full),
      .len_p  (len_p),
      .lnk_lt (ll),
      .age_lt (al),
      .lnk_rt (lr),
      .age_rt (ar),
      .lnk_o  (lnk[j]),
      .age_o  (age[j])
    );
  end

  // ---------------- median pick ----------------
  logic [AW-1:0] mid;
  assign mid = AW'(weff >> 1);

  always_comb begin
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_median_nxt = out_median_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_median_nxt = lnk[mid].val ^ swm_pkg::SIGN_FLIP;
      pend_nxt       = 1'b0;
    end
    if (accept) pend_nxt = produce;
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= swm_pkg::WINDOW_RESET;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ws_r        <= ws_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign ws_nxt = cfg_wr ? cfg_win_len : ws_r;

  always_ff @(posedge clk) begin
    out_median_r <= out_median_nxt;
  end

endmodule

// ----- design/swm_checker.sv -----
module swm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_median
);

  // a stalled result word stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_median))
    else $error("result word changed while stalled");

  // reset empties the output
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a fresh result needs a sample accepted before it
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a sample");

endmodule

bind sliding_window_median swm_checker u_swm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_median (out_median)
);

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W = swm_pkg::SAMPLE_W;
  localparam int CFG_W    = swm_pkg::CFG_W;
  localparam int WIN_MAX  = swm_pkg::MAX_WINDOW_DEF;
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = swm_pkg::SIGN_FLIP;
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = ~swm_pkg::SIGN_FLIP;
  // results leave through the pending and output registers; let the pipe
  // settle after a word that yields no result before any config write
  localparam int SETTLE     = 6;
  localparam int LONG_HOLD  = 80;   // one long output back-pressure stretch
  localparam int HOLD_AFTER = 30;   // words accepted before the long hold may start
  localparam int WD_LIMIT   = 1000; // cycles without any handshake

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       restart;
  } sample_word_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       in_new_sequence = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_median;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_W-1:0]           cfg_win_len = '0;

  sliding_window_median dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_new_sequence (in_new_sequence),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_median      (out_median),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_win_len     (cfg_win_len)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Median predictor: its own window in arrival order plus an ascending copy.
  // Updated at the edge a sample word is accepted.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] arrival_buf [WIN_MAX];
  logic signed [SAMPLE_W-1:0] sorted_buf  [WIN_MAX];
  int                         fill_cnt = 0;
  logic [CFG_W-1:0]           win_reg = swm_pkg::WINDOW_RESET;

  sample_word_t               pend_q[$];    // words waiting for the driver
  logic signed [SAMPLE_W-1:0] median_q[$];  // medians still to come out

  bit  quiet = 1'b0;     // no idling on either side from here on
  int  n_in = 0;         // sample words accepted
  int  errors = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  hold_done = 1'b0;
  int  idle_cycles = 0;
  logic signed [SAMPLE_W-1:0] exp_med;

  function automatic int eff_width(input logic [CFG_W-1:0] v);
    // zero acts as one, anything past the array clamps to its size
    if (v == 0) return 1;
    if (v > WIN_MAX) return WIN_MAX;
    return int'(v);
  endfunction

  function automatic void sorted_put(input int cnt, input logic signed [SAMPLE_W-1:0] v);
    int pos;
    pos = cnt;
    while (pos > 0 && sorted_buf[pos-1] > v) begin
      sorted_buf[pos] = sorted_buf[pos-1];
      pos--;
    end
    sorted_buf[pos] = v;
  endfunction

  // drop one copy only, so duplicates of the evicted value survive
  function automatic void sorted_drop(input int cnt, input logic signed [SAMPLE_W-1:0] v);
    int pos;
    pos = cnt - 1;
    for (int i = 0; i < cnt; i++) begin
      if (sorted_buf[i] == v) begin
        pos = i;
        break;
      end
    end
    for (int i = pos; i + 1 < cnt; i++) sorted_buf[i] = sorted_buf[i+1];
  endfunction

  function automatic void median_step(input logic signed [SAMPLE_W-1:0] smp,
                                      input logic restart);
    int w;
    logic signed [SAMPLE_W-1:0] oldest;
    w = eff_width(win_reg);
    if (restart) fill_cnt = 0;
    if (fill_cnt > w) fill_cnt = 0;
    if (fill_cnt < w) begin
      arrival_buf[fill_cnt] = smp;
      sorted_put(fill_cnt, smp);
      fill_cnt++;
    end else begin
      oldest = arrival_buf[0];
      for (int i = 0; i + 1 < w; i++) arrival_buf[i] = arrival_buf[i+1];
      arrival_buf[w-1] = smp;
      sorted_drop(w, oldest);
      sorted_put(w - 1, smp);
    end
    // upper median for even sizes
    if (fill_cnt == w) median_q.push_back(sorted_buf[w/2]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;                              // full range, every bit
      2:    return $signed($urandom_range(0, 6)) - 3;     // tight cluster -> duplicates
      3:    return $urandom_range(0, 1) ? SMP_MIN + $urandom_range(0, 2)
                                        : SMP_MAX - $urandom_range(0, 2);
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  function automatic void push_word(input logic signed [SAMPLE_W-1:0] smp,
                                    input logic restart);
    sample_word_t wd;
    wd.smp = smp;
    wd.restart = restart;
    pend_q.push_back(wd);
  endfunction

  // Mostly full sequences (long enough to slide), some no longer than the
  // window; a sequence usually opens with new_sequence but not always.
  task automatic queue_stream(input int w, input int count);
    int left, len;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) len = $urandom_range(1, w);
      else len = w + $urandom_range(0, 2 * w + 4);
      if (len > left) len = left;
      for (int k = 0; k < len; k++)
        push_word(rand_sample(), (k == 0) ? ($urandom_range(0, 5) != 0) : 1'b0);
      left -= len;
    end
  endtask

  // wait until every word is in and every median is out, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    while (pend_q.size() != 0 || in_valid || median_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] v);
    cfg_win_len <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    win_reg = v;
    fill_cnt = 0;   // a write restarts the sequence
  endtask

  // ---------------------------------------------------------------------------
  // Sample driver: presents pend_q[0], holds it while stalled, random gaps.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        median_step(pend_q[0].smp, pend_q[0].restart);
        void'(pend_q.pop_front());
        n_in <= n_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (!quiet && pend_q.size() != 0 && $urandom_range(0, 9) == 0) begin
          gap_left <= $urandom_range(0, 9);   // start a random idle burst
          in_valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          in_valid <= 1'b1;
          in_sample <= pend_q[0].smp;
          in_new_sequence <= pend_q[0].restart;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result back-pressure. One long hold once results flow, so the block backs
  // up and stalls its input; otherwise short random bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (!hold_done && n_in >= HOLD_AFTER && out_valid) begin
      out_stall <= 1'b1;
      stall_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (median_q.size() == 0) begin
        $display("%0t: median %0d with none expected", $time, out_median);
        errors++;
      end else begin
        exp_med = median_q.pop_front();
        if (out_median !== exp_med) begin
          $display("%0t: median expected %0d got %0d", $time, exp_med, out_median);
          errors++;
        end
      end
    end
  end

  // watchdog: too long without any handshake means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("[sliding_window_median] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] sweep [10];

  initial begin
    int w;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, at the reset window size of five
    push_word(SMP_MIN, 1'b1);
    push_word(SMP_MAX, 1'b0);
    push_word(0, 1'b0);
    push_word(-1, 1'b0);
    push_word(1, 1'b0);          // first median here
    push_word(SMP_MAX, 1'b0);
    push_word(SMP_MAX, 1'b0);
    push_word(SMP_MIN, 1'b0);
    push_word(SMP_MIN, 1'b0);
    push_word(SMP_MIN, 1'b0);
    // all-equal window: eviction takes one copy at a time
    push_word(3, 1'b1);
    push_word(3, 1'b0);
    push_word(3, 1'b0);
    push_word(3, 1'b0);
    push_word(3, 1'b0);
    push_word(2, 1'b0);
    push_word(4, 1'b0);
    // restart in the middle of a full window
    push_word(9, 1'b1);
    push_word(8, 1'b0);
    drain();

    // size zero behaves as one: every word is its own median
    write_window('0);
    @(negedge clk);
    push_word(SMP_MAX, 1'b1);
    push_word(SMP_MIN, 1'b0);
    push_word(0, 1'b1);
    queue_stream(1, 57);
    drain();

    // all ones clamps to the full array; 65 is just past it; 64 is the top
    sweep = '{7'd2, 7'd127, 7'd3, 7'd1, 7'd64, 7'd65, 7'd4,
              7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)), 7'd7};
    foreach (sweep[i]) begin
      write_window(sweep[i]);
      w = eff_width(sweep[i]);
      if (i == 9) quiet = 1'b1;   // last stretch runs at full rate
      @(negedge clk);
      queue_stream(w, (w >= 32) ? 120 : 60);
      drain();
    end

    if (errors == 0) $display("[sliding_window_median] OK");
    else $display("[sliding_window_median] ERROR");
    $finish;
  end

endmodule

// ----- sliding_window_median.f -----
design/swm_pkg.sv
design/swm_cell.sv
design/sliding_window_median.sv
design/swm_checker.sv
sim/tb_top.sv
